FILE: src/per_port_request_statistics_unit_defines.svh
// assertion macros shared by the statistics unit modules
// depends on nothing; users must have clk and rst_n in scope
`ifndef PER_PORT_REQUEST_STATISTICS_UNIT_DEFINES_SVH
`define PER_PORT_REQUEST_STATISTICS_UNIT_DEFINES_SVH

// same-cycle implication
`define PPRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/pprs_pkg.sv
// types and constants of the per-port request statistics unit
// depends on nothing
package pprs_pkg;

    // action codes of an input beat
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_RECORD = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    // quotient bits of the running-average divider
    localparam int DIV_STEPS = 32;

    typedef enum logic [1:0] {
        CLS_LOAD,
        CLS_RECORD,
        CLS_READ,
        CLS_REJECT
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [3:0]  idx;
        logic [31:0] ip;
        logic [15:0] port;
        logic [31:0] nread;
        logic [31:0] nsent;
        logic [23:0] conns;
        logic [23:0] busy;
        logic [31:0] now;
        logic [31:0] ms;
    } item_t;

    // front to back queue head
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_link_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] port;
        logic [31:0] total;
        logic [23:0] conns;
        logic [24:0] reqs;
        logic [63:0] bin;
        logic [63:0] bout;
        logic [31:0] tmin;
        logic [31:0] tmax;
        logic [31:0] tavg;
        logic [31:0] last;
        logic [31:0] rcur;
        logic [31:0] rprev;
    } row_t;

    typedef struct packed {
        logic        status;
        logic [3:0]  hit_index;
        logic [31:0] total;
        logic [23:0] conns;
        logic [24:0] reqs;
        logic [63:0] bin;
        logic [63:0] bout;
        logic [31:0] tmin;
        logic [31:0] tmax;
        logic [31:0] tavg;
        logic [31:0] rprev;
    } res_t;

endpackage

FILE: src/per_port_request_statistics_unit.sv
// Per-port request statistics unit.
// Input channel in_valid/in_stall carries one item per beat: action (load key,
// record finished request, read entry), entry index, endpoint key and request
// figures. Output channel out_valid/out_stall returns exactly one result beat per
// item: status, hit index and the entry's statistics after the update.
// A record runs the lookup scan over the entries, one multiply, one add, 32
// divider steps and one write-back; a record miss ends after the scan. One item
// is worked on at a time, set by the shared lookup/divider sequencer; a two-beat
// queue accepts items meanwhile.
// Reset clears all entries to invalid; a never-loaded entry reads as zero.
// When the receiver stalls the result stays in the output register, the back
// part takes no further item and the queue fills, then in_stall rises.
// depends on pprs_pkg, pprs_front and pprs_back
module per_port_request_statistics_unit
    import pprs_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [3:0]  entry_index,
    input  logic [31:0] local_ip,
    input  logic [15:0] local_port,
    input  logic [31:0] bytes_read,
    input  logic [31:0] bytes_sent,
    input  logic [23:0] active_connections,
    input  logic [23:0] busy_requests,
    input  logic [31:0] now_seconds,
    input  logic [31:0] elapsed_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [3:0]  hit_index,
    output logic [31:0] request_total,
    output logic [23:0] conn_active,
    output logic [24:0] req_active,
    output logic [63:0] bytes_in_total,
    output logic [63:0] bytes_out_total,
    output logic [31:0] resp_min_ms,
    output logic [31:0] resp_max_ms,
    output logic [31:0] resp_avg_ms,
    output logic [31:0] rate_prev_second
);

    q_link_t q;
    logic    pop;
    res_t    res;

    pprs_front #(.ENTRIES(ENTRIES)) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .action             (action),
        .entry_index        (entry_index),
        .local_ip           (local_ip),
        .local_port         (local_port),
        .bytes_read         (bytes_read),
        .bytes_sent         (bytes_sent),
        .active_connections (active_connections),
        .busy_requests      (busy_requests),
        .now_seconds        (now_seconds),
        .elapsed_ms         (elapsed_ms),
        .q                  (q),
        .pop                (pop)
    );

    pprs_back #(.ENTRIES(ENTRIES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q         (q),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    // result fields
    assign status           = res.status;
    assign hit_index        = res.hit_index;
    assign request_total    = res.total;
    assign conn_active      = res.conns;
    assign req_active       = res.reqs;
    assign bytes_in_total   = res.bin;
    assign bytes_out_total  = res.bout;
    assign resp_min_ms      = res.tmin;
    assign resp_max_ms      = res.tmax;
    assign resp_avg_ms      = res.tavg;
    assign rate_prev_second = res.rprev;

endmodule

FILE: src/pprs_front.sv
// front part: accepts input beats, classifies them and queues them
// depends on pprs_pkg and the assertion macro header
`include "per_port_request_statistics_unit_defines.svh"
module pprs_front
    import pprs_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [3:0]  entry_index,
    input  logic [31:0] local_ip,
    input  logic [15:0] local_port,
    input  logic [31:0] bytes_read,
    input  logic [31:0] bytes_sent,
    input  logic [23:0] active_connections,
    input  logic [23:0] busy_requests,
    input  logic [31:0] now_seconds,
    input  logic [31:0] elapsed_ms,
    output q_link_t     q,
    input  logic        pop
);

    item_t       item_in;
    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        in_range;

    // classify the incoming beat
    always_comb
    begin
        in_range          = int'(entry_index) < ENTRIES;
        item_in.idx       = entry_index;
        item_in.ip        = local_ip;
        item_in.port      = local_port;
        item_in.nread     = bytes_read;
        item_in.nsent     = bytes_sent;
        item_in.conns     = active_connections;
        item_in.busy      = busy_requests;
        item_in.now       = now_seconds;
        item_in.ms        = elapsed_ms;
        unique case (action)
            ACT_LOAD:   item_in.cls = in_range ? CLS_LOAD : CLS_REJECT;
            ACT_RECORD: item_in.cls = CLS_RECORD;
            ACT_READ:   item_in.cls = in_range ? CLS_READ : CLS_REJECT;
            default:    item_in.cls = CLS_REJECT;
        endcase
    end

    assign in_stall = count_reg == 2'd2;
    assign push     = in_valid && !in_stall;
    assign q.valid  = count_reg != 2'd0;
    assign q.item   = slot_reg[rd_ptr_reg];

    // two-slot queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    `PPRS_ASSERT_IMP(a_count_max, 1'b1, count_reg <= 2'd2, "queue overfilled")
    `PPRS_ASSERT_IMP(a_pop_nonempty, pop, count_reg != 2'd0, "pop from empty queue")
    `PPRS_ASSERT_NXT(a_push_count, push && !pop, count_reg == $past(count_reg) + 2'd1,
        "push lost")

endmodule

FILE: src/pprs_back.sv
// back part: entry table, lookup sequencer, running-average divider, result register
// depends on pprs_pkg and the assertion macro header
`include "per_port_request_statistics_unit_defines.svh"
module pprs_back
    import pprs_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_link_t q,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_stall,
    output res_t    res
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_READ = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_ADD  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_WB   = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    item_t            cur_reg, cur_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [ENTRIES-1:0] valid_reg;
    row_t             mem [ENTRIES];
    row_t             rd_reg;
    logic [63:0]      prod_reg;
    logic [32:0]      den_reg;
    logic [32:0]      rem_reg, rem_next;
    logic [31:0]      quo_reg, quo_next;
    logic [4:0]       cnt_reg, cnt_next;
    res_t             out_reg, out_next;
    logic             out_valid_reg;
    logic             out_load;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    row_t             mem_wd;
    logic             set_valid;
    logic             match;
    logic [63:0]      num;
    logic [33:0]      shifted;
    logic [33:0]      diff;
    row_t             upd;
    row_t             rd_row;

    function automatic res_t make_res(input row_t r, input logic [IDX_W-1:0] i);
        res_t x;
        x.status    = 1'b0;
        x.hit_index = 4'(i);
        x.total     = r.total;
        x.conns     = r.conns;
        x.reqs      = r.reqs;
        x.bin       = r.bin;
        x.bout      = r.bout;
        x.tmin      = r.tmin;
        x.tmax      = r.tmax;
        x.tavg      = r.tavg;
        x.rprev     = r.rprev;
        return x;
    endfunction

    function automatic res_t reject_res();
        res_t x;
        x        = '0;
        x.status = 1'b1;
        return x;
    endfunction

    assign match   = valid_reg[addr_reg] && rd_reg.ip == cur_reg.ip
                     && rd_reg.port == cur_reg.port;
    assign num     = prod_reg + 64'(cur_reg.ms);
    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = shifted - {1'b0, den_reg};
    assign rd_row  = valid_reg[addr_reg] ? rd_reg : '0;

    // updated row of a hit
    always_comb
    begin
        upd       = rd_reg;
        upd.total = rd_reg.total + 32'd1;
        upd.conns = cur_reg.conns;
        upd.reqs  = 25'(cur_reg.busy) + 25'd1;
        upd.bin   = rd_reg.bin + 64'(cur_reg.nread);
        upd.bout  = rd_reg.bout + 64'(cur_reg.nsent);
        if (cur_reg.now == rd_reg.last)
        begin
            upd.rcur = rd_reg.rcur + 32'd1;
        end
        else
        begin
            upd.rprev = rd_reg.rcur;
            upd.rcur  = 32'd1;
            upd.last  = cur_reg.now;
        end
        if (cur_reg.ms > rd_reg.tmax)
        begin
            upd.tmax = cur_reg.ms;
        end
        if (rd_reg.total == 32'd0 || cur_reg.ms < rd_reg.tmin)
        begin
            upd.tmin = cur_reg.ms;
        end
        upd.tavg = quo_reg;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        addr_next  = addr_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        out_load   = 1'b0;
        out_next   = out_reg;
        mem_we     = 1'b0;
        mem_wa     = addr_reg;
        mem_wd     = upd;
        set_valid  = 1'b0;
        pop        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q.valid && !out_valid_reg)
                begin
                    pop      = 1'b1;
                    cur_next = q.item;
                    unique case (q.item.cls)
                        CLS_LOAD:
                        begin
                            mem_we      = 1'b1;
                            mem_wa      = IDX_W'(q.item.idx);
                            mem_wd      = '0;
                            mem_wd.ip   = q.item.ip;
                            mem_wd.port = q.item.port;
                            set_valid   = 1'b1;
                            out_load    = 1'b1;
                            out_next    = make_res('0, IDX_W'(q.item.idx));
                        end
                        CLS_READ:
                        begin
                            addr_next  = IDX_W'(q.item.idx);
                            state_next = S_READ;
                        end
                        CLS_RECORD:
                        begin
                            addr_next  = '0;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                            out_next = reject_res();
                        end
                    endcase
                end
            end
            S_READ:
            begin
                out_load   = 1'b1;
                out_next   = make_res(rd_row, addr_reg);
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (match)
                begin
                    state_next = S_MUL;
                end
                else if (addr_reg == LAST_IDX)
                begin
                    out_load   = 1'b1;
                    out_next   = reject_res();
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                rem_next   = {1'b0, num[63:32]};
                quo_next   = num[31:0];
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!diff[33])
                begin
                    rem_next = diff[32:0];
                end
                else
                begin
                    rem_next = shifted[32:0];
                end
                quo_next = {quo_reg[30:0], !diff[33]};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                mem_we     = 1'b1;
                out_load   = 1'b1;
                out_next   = make_res(upd, addr_reg);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // entry table, registered read at the next address
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_reg <= mem[addr_next];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        prod_reg <= rd_reg.tavg * rd_reg.total;
        den_reg  <= {1'b0, rd_reg.total} + 33'd1;
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            addr_reg      <= '0;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            cnt_reg   <= cnt_next;
            if (set_valid)
            begin
                valid_reg[mem_wa] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = out_reg;

    `PPRS_ASSERT_IMP(a_pop_out_free, pop, !out_valid_reg, "pop while result pending")
    `PPRS_ASSERT_IMP(a_wb_valid, state_reg == S_WB, valid_reg[addr_reg],
        "write-back to invalid entry")
    `PPRS_ASSERT_IMP(a_div_rem, state_reg == S_DIV, rem_reg < den_reg,
        "divider remainder out of range")
    `PPRS_ASSERT_NXT(a_out_gap, out_valid_reg && !out_stall, !out_valid_reg,
        "result beat repeated")

endmodule
